[rtl/core/fixed_point_to_decimal_text_macros.svh]
`ifndef FIXED_POINT_TO_DECIMAL_TEXT_MACROS_SVH
`define FIXED_POINT_TO_DECIMAL_TEXT_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define FTDT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define FTDT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ftdt_pkg.sv]
package ftdt_pkg;

    localparam int INT_BITS   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = INT_BITS + FRAC_BITS;

    localparam int          PLACES_W   = 4;
    localparam logic [3:0]  MAX_PLACES = 4'd9;
    localparam logic [3:0]  RST_PLACES = 4'd4;

    // 10^9 fits in 30 bits, so does any rounded fraction
    localparam int FDIG_BITS = 30;
    localparam int ACC_BITS  = FRAC_BITS + FDIG_BITS;

    localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_POINT = 8'h2E;

    // decimal digits needed for any value of the given bit width
    function automatic int ftdt_dec_digits(input int bits);
        longint unsigned v;
        int n;
        v = (64'd1 << bits) - 64'd1;
        n = 0;
        while (v != 0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

    // integer part gains one bit for the rounding carry
    localparam int DD_BITS   = (INT_BITS + 1 > FDIG_BITS) ? INT_BITS + 1 : FDIG_BITS;
    localparam int DD_DIGITS = ftdt_dec_digits(DD_BITS);
    localparam int DD_CNT_W  = $clog2(DD_BITS + 1);
    localparam int DIG_IDX_W = $clog2(DD_DIGITS);

    function automatic logic [FDIG_BITS-1:0] ftdt_pow10(input logic [PLACES_W-1:0] p);
        logic [FDIG_BITS-1:0] r;
        case (p)
            4'd0:    r = FDIG_BITS'(1);
            4'd1:    r = FDIG_BITS'(10);
            4'd2:    r = FDIG_BITS'(100);
            4'd3:    r = FDIG_BITS'(1000);
            4'd4:    r = FDIG_BITS'(10000);
            4'd5:    r = FDIG_BITS'(100000);
            4'd6:    r = FDIG_BITS'(1000000);
            4'd7:    r = FDIG_BITS'(10000000);
            4'd8:    r = FDIG_BITS'(100000000);
            default: r = FDIG_BITS'(1000000000);
        endcase
        return r;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CONVERT,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } ftdt_state_t;

    typedef struct packed {
        logic                 done;
        logic                 carry;
        logic [FDIG_BITS-1:0] fdig;
    } ftdt_frac_res_t;

endpackage

[rtl/core/fixed_point_to_decimal_text.sv]
// channel   direction  handshake            payload
// input     in         in_valid, in_stall   value[47:0]
// output    out        out_valid, out_stall character[7:0], last
// config    in         cfg_write            cfg_data[3:0] (frac_places)
//
// one value takes times-ten scaling once per fraction place and rounding, then
// bit-serial binary to bcd for both parts at once, then one character per cycle
// while the output is not stalled
// reset clears the sequencer and output valid, frac_places goes to 4
// in_stall is high from an accepted beat until its last character sits in the
// output register; out_stall holds that register and pauses the emit sequencer

`include "fixed_point_to_decimal_text_macros.svh"

module fixed_point_to_decimal_text import ftdt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [PLACES_W-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [VALUE_BITS-1:0]   value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              character,
    output logic                    last
);

    ftdt_state_t             state_reg, state_next;
    logic [PLACES_W-1:0]     frac_places_reg;
    logic [PLACES_W-1:0]     places_reg, places_next;
    logic [INT_BITS-1:0]     ipart_reg, ipart_next;
    logic [DIG_IDX_W-1:0]    int_idx_reg, int_idx_next;
    logic [DIG_IDX_W-1:0]    frac_idx_reg, frac_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              character_reg, character_next;
    logic                    last_reg, last_next;

    logic                    accept;
    logic                    can_push;
    logic                    dd_load;
    logic [DD_BITS-1:0]      int_value;
    logic [DD_BITS-1:0]      frac_value;
    logic [DD_DIGITS*4-1:0]  int_bcd;
    logic [DD_DIGITS*4-1:0]  frac_bcd;
    logic                    dd_int_done;
    logic                    dd_frac_done;
    logic [DIG_IDX_W-1:0]    int_top;
    logic [3:0]              int_digit;
    logic [3:0]              frac_digit;
    ftdt_frac_res_t          frac_res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign can_push = !out_valid_reg || !out_stall;
    assign dd_load  = (state_reg == ST_SCALE) && frac_res.done;

    assign places_next = (frac_places_reg > MAX_PLACES) ? MAX_PLACES : frac_places_reg;
    assign ipart_next  = value[FRAC_BITS +: INT_BITS];

    assign int_value  = DD_BITS'(ipart_reg) + DD_BITS'(frac_res.carry);
    assign frac_value = DD_BITS'(frac_res.fdig);

    ftdt_frac u_frac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .frac   (value[FRAC_BITS-1:0]),
        .places (places_next),
        .res    (frac_res)
    );

    ftdt_dabble u_dd_int
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (dd_load),
        .din   (int_value),
        .bcd   (int_bcd),
        .done  (dd_int_done)
    );

    ftdt_dabble u_dd_frac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (dd_load),
        .din   (frac_value),
        .bcd   (frac_bcd),
        .done  (dd_frac_done)
    );

    // highest nonzero integer digit, digit zero when the part is zero
    always_comb
    begin
        int_top = '0;
        for (int i = 1; i < DD_DIGITS; i++)
        begin
            if (int_bcd[i*4 +: 4] != 4'd0)
            begin
                int_top = DIG_IDX_W'(i);
            end
        end
    end

    assign int_digit  = int_bcd[int_idx_reg*4 +: 4];
    assign frac_digit = frac_bcd[frac_idx_reg*4 +: 4];

    always_comb
    begin
        state_next     = state_reg;
        int_idx_next   = int_idx_reg;
        frac_idx_next  = frac_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        character_next = character_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (frac_res.done)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (dd_int_done)
                begin
                    state_next   = ST_INT;
                    int_idx_next = int_top;
                end
            end
            ST_INT:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    character_next = ASCII_ZERO + {4'b0, int_digit};
                    last_next      = 1'b0;
                    if (int_idx_reg == '0)
                    begin
                        state_next = ST_POINT;
                    end
                    else
                    begin
                        int_idx_next = int_idx_reg - DIG_IDX_W'(1);
                    end
                end
            end
            ST_POINT:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    character_next = ASCII_POINT;
                    last_next      = (places_reg == '0);
                    if (places_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next    = ST_FRAC;
                        frac_idx_next = DIG_IDX_W'(places_reg - PLACES_W'(1));
                    end
                end
            end
            ST_FRAC:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    character_next = ASCII_ZERO + {4'b0, frac_digit};
                    last_next      = (frac_idx_reg == '0);
                    if (frac_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        frac_idx_next = frac_idx_reg - DIG_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frac_places_reg <= RST_PLACES;
            out_valid_reg   <= 1'b0;
            int_idx_reg     <= '0;
            frac_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            int_idx_reg   <= int_idx_next;
            frac_idx_reg  <= frac_idx_next;
            if (cfg_write)
            begin
                frac_places_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            places_reg <= places_next;
            ipart_reg  <= ipart_next;
        end
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    `FTDT_ASSERT_NXT(a_accept_starts, accept, state_reg == ST_SCALE, "accepted beat did not start scaling")
    `FTDT_ASSERT_IMP(a_char_legal, out_valid, (character >= ASCII_ZERO && character <= ASCII_NINE) || character == ASCII_POINT, "output beat is not a digit or point")
    `FTDT_ASSERT_IMP(a_round_range, frac_res.done, frac_res.fdig < ftdt_pow10(places_reg), "rounded fraction not below its scale")
    `FTDT_ASSERT_IMP(a_dd_lockstep, dd_int_done || dd_frac_done, dd_int_done && dd_frac_done && state_reg == ST_CONVERT, "bcd converters out of step")

endmodule

[rtl/core/ftdt_dabble.sv]
module ftdt_dabble import ftdt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [DD_BITS-1:0]       din,
    output logic [DD_DIGITS*4-1:0]   bcd,
    output logic                     done
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DD_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DD_BITS-1:0]     bin_reg, bin_next;
    logic [DD_DIGITS*4-1:0] bcd_reg, bcd_next;
    logic [DD_DIGITS*4-1:0] adj;

    // add three to every digit of five or more, then shift one bit in
    always_comb
    begin
        for (int i = 0; i < DD_DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                         : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = DD_CNT_W'(DD_BITS);
            bin_next  = din;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[DD_DIGITS*4-2:0], bin_reg[DD_BITS-1]};
            bin_next = {bin_reg[DD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - DD_CNT_W'(1);
            if (cnt_reg == DD_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd  = bcd_reg;
    assign done = done_reg;

endmodule

[rtl/core/ftdt_frac.sv]
module ftdt_frac import ftdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FRAC_BITS-1:0]  frac,
    input  logic [PLACES_W-1:0]   places,
    output ftdt_frac_res_t        res
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [PLACES_W-1:0]    cnt_reg, cnt_next;
    logic [PLACES_W-1:0]    places_reg, places_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [FDIG_BITS-1:0]   fdig_reg, fdig_next;
    logic                   carry_reg, carry_next;
    logic [ACC_BITS:0]      round_sum;
    logic [FDIG_BITS-1:0]   quot;
    logic [FDIG_BITS-1:0]   scale;
    logic                   over;

    always_comb
    begin
        round_sum = {1'b0, acc_reg} + ROUND_HALF;
        quot      = round_sum[FRAC_BITS +: FDIG_BITS];
        scale     = ftdt_pow10(places_reg);
        over      = (quot >= scale);
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        places_next = places_reg;
        acc_next    = acc_reg;
        fdig_next   = fdig_reg;
        carry_next  = carry_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = places;
            places_next = places;
            acc_next    = ACC_BITS'(frac);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // times ten as 8x + 2x
                acc_next = (acc_reg << 3) + (acc_reg << 1);
                cnt_next = cnt_reg - PLACES_W'(1);
            end
            else
            begin
                // round to places digits; a result that reached 10^places carries into the integer part
                busy_next  = 1'b0;
                done_next  = 1'b1;
                carry_next = over;
                fdig_next  = over ? quot - scale : quot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        places_reg <= places_next;
        acc_reg    <= acc_next;
        fdig_reg   <= fdig_next;
        carry_reg  <= carry_next;
    end

    assign res.done  = done_reg;
    assign res.carry = carry_reg;
    assign res.fdig  = fdig_reg;

endmodule

[verif/tb_fixed_point_to_decimal_text.sv]
`timescale 1ns / 1ps

module tb_fixed_point_to_decimal_text;
    import ftdt_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 15;
    localparam int DIRECTED_ROWS = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    typedef struct {
        logic [PLACES_W-1:0]   places;
        logic [VALUE_BITS-1:0] v;
        string                 text;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [PLACES_W-1:0]   cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] value;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            character;
    logic                  last;

    text_beat_t          text_expected [$];
    logic [PLACES_W-1:0] places_reg = RST_PLACES;
    int                  error_count = 0;
    int                  cycle_count = 0;
    bit                  hold_request = 1'b0;

    // empty text means the row is checked against the predictor
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{4'd4,  48'h0000_0000_0000, "0.0000"},
        '{4'd4,  48'hFFFF_FFFF_FFFF, "4294967296.0000"},
        '{4'd4,  48'hAAAA_AAAA_AAAA, ""},
        '{4'd4,  48'h5555_5555_5555, ""},
        '{4'd0,  48'h0000_0000_8000, "1."},
        '{4'd0,  48'h0000_0000_7FFF, "0."},
        '{4'd0,  48'hFFFF_FFFF_FFFF, "4294967296."},
        '{4'd9,  48'h0000_0000_0001, ""},
        '{4'd9,  48'hFFFF_FFFF_FFFF, ""},
        '{4'd9,  48'h0000_0001_0000, "1.000000000"},
        '{4'd15, 48'h0000_0000_0000, "0.000000000"},
        '{4'd12, 48'h0001_0000_0000, "65536.000000000"},
        '{4'd1,  48'h0000_0000_8000, "0.5"},
        '{4'd1,  48'h0000_0000_FFFF, "1.0"},
        '{4'd3,  48'h8000_0000_0000, "2147483648.000"},
        '{4'd2,  48'h0000_0009_0000, "9.00"},
        '{4'd2,  48'h0000_000A_0000, "10.00"},
        '{4'd2,  48'h0000_0000_147B, ""},
        '{4'd5,  48'h0000_00FF_FFFF, ""},
        '{4'd4,  48'h0000_0000_FFFE, ""}
    };

    fixed_point_to_decimal_text i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decimal text of one value at the current number of places
    function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
        logic [INT_BITS:0]   whole;
        logic [63:0]         frac;
        logic [63:0]         scale;
        logic [63:0]         fdig;
        logic [PLACES_W-1:0] places;
        logic [7:0]          int_chars [$];
        logic [7:0]          frac_chars [$];
        int                  k;
        whole  = {1'b0, v[VALUE_BITS-1:FRAC_BITS]};
        frac   = 64'(v[FRAC_BITS-1:0]);
        places = (places_reg > MAX_PLACES) ? MAX_PLACES : places_reg;
        scale  = 64'd1;
        for (k = 0; k < places; k++)
            scale = scale * 64'd10;
        fdig = (frac * scale + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // rounding carry moves into the integer part
        if (fdig >= scale)
        begin
            fdig  = fdig - scale;
            whole = whole + 1'b1;
        end
        do
        begin
            int_chars.push_front(ASCII_ZERO + 8'(whole % 10));
            whole = whole / 10;
        end
        while (whole != 0);
        for (k = 0; k < places; k++)
        begin
            frac_chars.push_front(ASCII_ZERO + 8'(fdig % 10));
            fdig = fdig / 10;
        end
        foreach (int_chars[j])
            text_expected.push_back('{int_chars[j], 1'b0});
        text_expected.push_back('{ASCII_POINT, places == 0});
        foreach (frac_chars[j])
            text_expected.push_back('{frac_chars[j], j == frac_chars.size() - 1});
    endfunction

    function automatic void expect_string(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            text_expected.push_back('{8'(s[k]), k == s.len() - 1});
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [31:0] whole;
        logic [15:0] frac;
        int          pick;
        pick = $urandom_range(0, 9);
        frac = 16'($urandom);
        case (pick)
            0, 1, 2, 3: whole = $urandom_range(0, 999);
            4, 5:       whole = $urandom;
            6:
            begin
                whole = $urandom;
                case ($urandom_range(0, 3))
                    0:       frac = 16'h0000;
                    1:       frac = 16'hFFFF;
                    2:       frac = 16'h8000;
                    default: frac = 16'h7FFF;
                endcase
            end
            7:
            begin
                // all-nines and all-ones integer parts let the rounding carry ripple
                case ($urandom_range(0, 3))
                    0:       whole = 32'd9;
                    1:       whole = 32'd99999;
                    2:       whole = 32'd999999999;
                    default: whole = 32'hFFFF_FFFF;
                endcase
                frac = 16'hFFFF;
            end
            default: whole = $urandom >> $urandom_range(0, 31);
        endcase
        return {whole, frac};
    endfunction

    // offer one value and hold it until the block takes it
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string text);
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (text.len() == 0)
            predict_text(v);
        else
            expect_string(text);
    endtask

    task automatic wait_text_drained();
        while (text_expected.size() != 0)
            @(posedge clk);
    endtask

    // only called with in_valid already low
    task automatic set_places(input logic [PLACES_W-1:0] p);
        wait_text_drained();
        repeat (2) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= p;
        @(posedge clk);
        cfg_write  <= 1'b0;
        places_reg = p;
    endtask

    // receiver: stall pattern in segments, plus one long hold-off on request
    initial
    begin
        int seg_left;
        int stall_pct;
        int hold_left;
        out_stall = 1'b0;
        seg_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 100);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        text_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (text_expected.size() == 0)
            begin
                $error("unexpected character beat: character %h last %b", character, last);
                error_count++;
            end
            else
            begin
                exp_beat = text_expected.pop_front();
                if (character !== exp_beat.ch)
                begin
                    $error("character: expected %h, actual %h", exp_beat.ch, character);
                    error_count++;
                end
                if (last !== exp_beat.last)
                begin
                    $error("last: expected %b, actual %b", exp_beat.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int                  r;
        int                  ph;
        int                  i;
        int                  burst_left;
        logic [PLACES_W-1:0] phase_places [PHASE_COUNT];
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        value     = '0;
        phase_places = '{4'd0, 4'd9, 4'd15, 4'($urandom_range(1, 8)),
                         4'($urandom_range(0, 15)), 4'd10};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].places != places_reg)
                set_places(directed_rows[r].places);
            offer_value(directed_rows[r].v, directed_rows[r].text);
            if (r == DIRECTED_ROWS - 1 || directed_rows[r + 1].places != places_reg)
                in_valid <= 1'b0;
        end

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_places(phase_places[ph]);
            // long receiver hold-off while the sender keeps offering
            if (ph == 1)
                hold_request = 1'b1;
            burst_left = $urandom_range(1, 8);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                offer_value(random_value(), "");
                burst_left--;
                if (i == PHASE_ITEMS - 1 || burst_left == 0 || (ph == 3 && i == 8))
                begin
                    in_valid <= 1'b0;
                    if (ph == 3 && i == 8)
                        wait_text_drained();
                    else
                        repeat ($urandom_range(1, 15)) @(posedge clk);
                    burst_left = $urandom_range(1, 8);
                end
            end
        end

        wait_text_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ftdt_pkg.sv
rtl/core/ftdt_dabble.sv
rtl/core/ftdt_frac.sv
rtl/core/fixed_point_to_decimal_text.sv
verif/tb_fixed_point_to_decimal_text.sv
